// ===== sv/phc_pkg.sv =====
// Shared types, constants and helpers for the packet header checker.
package phc_pkg;

   localparam int unsigned DATA_WIDTH    = 8;
   localparam int unsigned COUNT_WIDTH   = 13;
   localparam int unsigned CSR_WIDTH     = 13;
   localparam int unsigned CSR_IDX_WIDTH = 2;
   localparam int unsigned QUEUE_DEPTH   = 2;

   localparam logic [COUNT_WIDTH-1:0] HEADER_BYTES = COUNT_WIDTH'(16);
   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX    = '1;

   localparam logic [7:0] MAGIC_0 = 8'h43;  // C
   localparam logic [7:0] MAGIC_1 = 8'h49;  // I
   localparam logic [7:0] MAGIC_2 = 8'h46;  // F
   localparam logic [7:0] MAGIC_3 = 8'h54;  // T

   localparam logic [CSR_IDX_WIDTH-1:0] CSR_EXPECTED_VERSION  = 2'd0;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_TYPE_LOWEST       = 2'd1;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_TYPE_HIGHEST      = 2'd2;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_MAX_PACKET_LENGTH = 2'd3;

   typedef enum logic [2:0] {
      STATUS_OK       = 3'd0,
      STATUS_SHORT    = 3'd1,
      STATUS_LONG     = 3'd2,
      STATUS_MAGIC    = 3'd3,
      STATUS_VERSION  = 3'd4,
      STATUS_MISMATCH = 3'd5,
      STATUS_TYPE     = 3'd6
   } status_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [7:0]  packet_type;
      logic [31:0] session_id;
      logic [31:0] sequence_number;
      logic [15:0] payload_length;
   } rsp_type;

   typedef struct packed {
      logic [7:0]  expected_version;
      logic [7:0]  type_lowest;
      logic [7:0]  type_highest;
      logic [12:0] max_packet_length;
   } cfg_type;

   // One finished packet as handed from the front end to the back end.
   typedef struct packed {
      logic [COUNT_WIDTH-1:0] total;
      logic                   magic_good;
      logic                   version_good;
      logic [7:0]             packet_type;
      logic [15:0]            payload_length;
      logic [31:0]            session_id;
      logic [31:0]            sequence_number;
   } summary_type;

   function automatic logic [7:0] magic_byte(input logic [1:0] pos);
      logic [7:0] value;
      case (pos)
         2'd0:    value = MAGIC_0;
         2'd1:    value = MAGIC_1;
         2'd2:    value = MAGIC_2;
         default: value = MAGIC_3;
      endcase
      return value;
   endfunction

endpackage

// ===== sv/phc_front.sv =====
// Front end: takes packet bytes, collects header fields and emits one summary per packet.
module phc_front
   import phc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  req_type     req_data,
   input  logic [7:0]  expected_version,
   input  logic        queue_full,
   output logic        push,
   output summary_type push_data
);

   logic [COUNT_WIDTH-1:0] count_ff, count_in, count_upd;
   logic                   magic_ff, magic_in, magic_upd;
   logic                   version_ff, version_in, version_upd;
   logic [7:0]             type_ff, type_in, type_upd;
   logic [15:0]            length_ff, length_in, length_upd;
   logic [31:0]            session_ff, session_in, session_upd;
   logic [31:0]            sequence_ff, sequence_in, sequence_upd;
   logic                   accept;

   assign req_ready = !queue_full;
   assign accept    = req_valid && req_ready;
   assign push      = accept && req_data.last_byte;

   always_comb begin
      magic_upd    = magic_ff;
      version_upd  = version_ff;
      type_upd     = type_ff;
      length_upd   = length_ff;
      session_upd  = session_ff;
      sequence_upd = sequence_ff;
      if (count_ff < COUNT_WIDTH'(4)) begin
         if (req_data.data_byte != magic_byte(count_ff[1:0])) begin
            magic_upd = 1'b0;
         end
      end else begin
         case (count_ff)
            COUNT_WIDTH'(4): begin
               if (req_data.data_byte != expected_version) begin
                  version_upd = 1'b0;
               end
            end
            COUNT_WIDTH'(5):  type_upd              = req_data.data_byte;
            COUNT_WIDTH'(6):  length_upd[7:0]       = req_data.data_byte;
            COUNT_WIDTH'(7):  length_upd[15:8]      = req_data.data_byte;
            COUNT_WIDTH'(8):  session_upd[7:0]      = req_data.data_byte;
            COUNT_WIDTH'(9):  session_upd[15:8]     = req_data.data_byte;
            COUNT_WIDTH'(10): session_upd[23:16]    = req_data.data_byte;
            COUNT_WIDTH'(11): session_upd[31:24]    = req_data.data_byte;
            COUNT_WIDTH'(12): sequence_upd[7:0]     = req_data.data_byte;
            COUNT_WIDTH'(13): sequence_upd[15:8]    = req_data.data_byte;
            COUNT_WIDTH'(14): sequence_upd[23:16]   = req_data.data_byte;
            COUNT_WIDTH'(15): sequence_upd[31:24]   = req_data.data_byte;
            default: ;
         endcase
      end
      count_upd = (count_ff == COUNT_MAX) ? count_ff : count_ff + COUNT_WIDTH'(1);
   end

   always_comb begin
      count_in    = count_ff;
      magic_in    = magic_ff;
      version_in  = version_ff;
      type_in     = type_ff;
      length_in   = length_ff;
      session_in  = session_ff;
      sequence_in = sequence_ff;
      if (accept) begin
         if (req_data.last_byte) begin
            count_in    = '0;
            magic_in    = 1'b1;
            version_in  = 1'b1;
            type_in     = '0;
            length_in   = '0;
            session_in  = '0;
            sequence_in = '0;
         end else begin
            count_in    = count_upd;
            magic_in    = magic_upd;
            version_in  = version_upd;
            type_in     = type_upd;
            length_in   = length_upd;
            session_in  = session_upd;
            sequence_in = sequence_upd;
         end
      end
   end

   always_comb begin
      push_data.total           = count_upd;
      push_data.magic_good      = magic_upd;
      push_data.version_good    = version_upd;
      push_data.packet_type     = type_upd;
      push_data.payload_length  = length_upd;
      push_data.session_id      = session_upd;
      push_data.sequence_number = sequence_upd;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= '0;
         magic_ff    <= 1'b1;
         version_ff  <= 1'b1;
         type_ff     <= '0;
         length_ff   <= '0;
         session_ff  <= '0;
         sequence_ff <= '0;
      end else begin
         count_ff    <= count_in;
         magic_ff    <= magic_in;
         version_ff  <= version_in;
         type_ff     <= type_in;
         length_ff   <= length_in;
         session_ff  <= session_in;
         sequence_ff <= sequence_in;
      end
   end

endmodule

// ===== sv/phc_queue.sv =====
// Short FIFO of packet summaries between the front and back ends.
module phc_queue
   import phc_pkg::*;
#(
   parameter int unsigned Depth = QUEUE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   input  summary_type push_data,
   output logic        full,
   input  logic        pop,
   output logic        not_empty,
   output summary_type pop_data
);

   localparam int unsigned PtrWidth   = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int unsigned CountWidth = $clog2(Depth + 1);
   localparam logic [PtrWidth-1:0]   LastPtr   = PtrWidth'(Depth - 1);
   localparam logic [CountWidth-1:0] FullCount = CountWidth'(Depth);

   summary_type             entry_ff [Depth];
   logic [PtrWidth-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PtrWidth-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CountWidth-1:0]   count_ff, count_in;
   logic                    do_push, do_pop;

   assign full      = (count_ff == FullCount);
   assign not_empty = (count_ff != '0);
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;
   assign pop_data  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LastPtr) ? '0 : wr_ptr_ff + PtrWidth'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LastPtr) ? '0 : rd_ptr_ff + PtrWidth'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CountWidth'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CountWidth'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== sv/phc_back.sv =====
// Back end: runs the prioritized checks on a summary and holds the result for the receiver.
module phc_back
   import phc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        queue_not_empty,
   input  summary_type queue_data,
   output logic        pop,
   input  cfg_type     cfg,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_data
);

   logic       rsp_valid_ff, rsp_valid_in;
   rsp_type    rsp_ff, rsp_in;
   status_type status;
   logic [16:0] expected_total;

   assign pop       = queue_not_empty && (!rsp_valid_ff || rsp_ready);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   assign expected_total = 17'(queue_data.payload_length) + 17'(HEADER_BYTES);

   always_comb begin
      if (queue_data.total < HEADER_BYTES) begin
         status = STATUS_SHORT;
      end else if (queue_data.total == COUNT_MAX
                   || queue_data.total > cfg.max_packet_length) begin
         status = STATUS_LONG;
      end else if (!queue_data.magic_good) begin
         status = STATUS_MAGIC;
      end else if (!queue_data.version_good) begin
         status = STATUS_VERSION;
      end else if (17'(queue_data.total) != expected_total) begin
         status = STATUS_MISMATCH;
      end else if (queue_data.packet_type < cfg.type_lowest
                   || queue_data.packet_type > cfg.type_highest) begin
         status = STATUS_TYPE;
      end else begin
         status = STATUS_OK;
      end
   end

   always_comb begin
      rsp_in.status          = status;
      rsp_in.packet_type     = '0;
      rsp_in.session_id      = '0;
      rsp_in.sequence_number = '0;
      rsp_in.payload_length  = '0;
      if (status == STATUS_OK) begin
         rsp_in.packet_type     = queue_data.packet_type;
         rsp_in.session_id      = queue_data.session_id;
         rsp_in.sequence_number = queue_data.sequence_number;
         rsp_in.payload_length  = queue_data.payload_length;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (pop) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule

// ===== sv/packet_header_checker.sv =====
// Top level of the packet header checker: config registers and the front/queue/back chain.
//
// Usage:
//   req_* carries one packet byte per item with a last-byte flag. The header (magic,
//   version, type, payload length, session id, sequence) is collected as bytes pass;
//   payload bytes are only counted. On the last byte one result item leaves on rsp_*
//   with a status and, when the status is ok, the decoded header fields.
//   csr_* writes the expected version, the type range and the maximum packet length;
//   write only while no packet is in progress or pending.
// Timing:
//   One byte per cycle sustained while the summary queue is not full. A result item passes
//   through the summary queue, written by the edge that accepts its last byte, and then the
//   output register, loaded by the checks once it is free. The queue holds QueueDepth packets.
// Reset:
//   Synchronous, active high; clears the byte count, the queue and the output valid,
//   and loads version 1, type range 0..255 and maximum length 250.
// Stall:
//   While rsp_ready is low the result holds; bytes of a packet keep flowing, and req_ready
//   drops only when the summary queue is full.
module packet_header_checker
   import phc_pkg::*;
#(
   parameter int unsigned QueueDepth = QUEUE_DEPTH
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  req_type                  req_data,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output rsp_type                  rsp_data,
   input  logic                     csr_write_enable,
   input  logic [CSR_IDX_WIDTH-1:0] csr_index,
   input  logic [CSR_WIDTH-1:0]     csr_write_data
);

   cfg_type     cfg_ff, cfg_in;
   logic        queue_full, queue_not_empty;
   logic        push, pop;
   summary_type push_data, pop_data;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_EXPECTED_VERSION:  cfg_in.expected_version  = csr_write_data[7:0];
            CSR_TYPE_LOWEST:       cfg_in.type_lowest       = csr_write_data[7:0];
            CSR_TYPE_HIGHEST:      cfg_in.type_highest      = csr_write_data[7:0];
            CSR_MAX_PACKET_LENGTH: cfg_in.max_packet_length = csr_write_data[12:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.expected_version  <= 8'd1;
         cfg_ff.type_lowest       <= 8'd0;
         cfg_ff.type_highest      <= 8'd255;
         cfg_ff.max_packet_length <= 13'd250;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   phc_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_data         (req_data),
      .expected_version (cfg_ff.expected_version),
      .queue_full       (queue_full),
      .push             (push),
      .push_data        (push_data)
   );

   phc_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (queue_full),
      .pop       (pop),
      .not_empty (queue_not_empty),
      .pop_data  (pop_data)
   );

   phc_back u_back (
      .clock           (clock),
      .reset           (reset),
      .queue_not_empty (queue_not_empty),
      .queue_data      (pop_data),
      .pop             (pop),
      .cfg             (cfg_ff),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_data        (rsp_data)
   );

endmodule

// ===== dv/testbench.sv =====
// Self-checking testbench for packet_header_checker: byte stream stimulus, header predictor.
`timescale 1ns / 1ps

module testbench;
   import phc_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;

   class header_tracker;
      logic [7:0]  version_reg;
      logic [7:0]  type_low;
      logic [7:0]  type_high;
      logic [12:0] length_limit;
      logic [12:0] byte_count;
      bit          magic_ok;
      bit          version_ok;
      logic [7:0]  type_field;
      logic [15:0] length_field;
      logic [31:0] session_field;
      logic [31:0] sequence_field;
      rsp_type     due_reports[$];
      int          mismatches;

      function new();
         version_reg = 8'd1;
         type_low = 8'd0;
         type_high = 8'd255;
         length_limit = 13'd250;
         mismatches = 0;
         restart();
      endfunction

      function void restart();
         byte_count = '0;
         magic_ok = 1'b1;
         version_ok = 1'b1;
         type_field = '0;
         length_field = '0;
         session_field = '0;
         sequence_field = '0;
      endfunction

      function void set_register(logic [CSR_IDX_WIDTH-1:0] idx, logic [CSR_WIDTH-1:0] value);
         case (idx)
            CSR_EXPECTED_VERSION:  version_reg = value[7:0];
            CSR_TYPE_LOWEST:       type_low = value[7:0];
            CSR_TYPE_HIGHEST:      type_high = value[7:0];
            CSR_MAX_PACKET_LENGTH: length_limit = value[12:0];
            default: ;
         endcase
      endfunction

      function void take_byte(req_type item);
         int         pos;
         logic [7:0] want;
         status_type verdict;
         rsp_type    report;
         pos = int'(byte_count);
         if (pos < 4) begin
            case (pos)
               0:       want = MAGIC_0;
               1:       want = MAGIC_1;
               2:       want = MAGIC_2;
               default: want = MAGIC_3;
            endcase
            if (item.data_byte != want) magic_ok = 1'b0;
         end else if (pos == 4) begin
            if (item.data_byte != version_reg) version_ok = 1'b0;
         end else if (pos == 5) begin
            type_field = item.data_byte;
         end else if (pos < 8) begin
            length_field[8*(pos-6) +: 8] = item.data_byte;
         end else if (pos < 12) begin
            session_field[8*(pos-8) +: 8] = item.data_byte;
         end else if (pos < 16) begin
            sequence_field[8*(pos-12) +: 8] = item.data_byte;
         end
         if (byte_count != COUNT_MAX) byte_count++;
         if (!item.last_byte) return;

         if (byte_count < HEADER_BYTES) verdict = STATUS_SHORT;
         else if (byte_count == COUNT_MAX || byte_count > length_limit) verdict = STATUS_LONG;
         else if (!magic_ok) verdict = STATUS_MAGIC;
         else if (!version_ok) verdict = STATUS_VERSION;
         else if (int'(byte_count) != int'(HEADER_BYTES) + int'(length_field))
            verdict = STATUS_MISMATCH;
         else if (type_field < type_low || type_field > type_high) verdict = STATUS_TYPE;
         else verdict = STATUS_OK;

         report = '0;
         report.status = verdict;
         if (verdict == STATUS_OK) begin
            report.packet_type = type_field;
            report.session_id = session_field;
            report.sequence_number = sequence_field;
            report.payload_length = length_field;
         end
         due_reports.push_back(report);
         restart();
      endfunction

      function void match_result(rsp_type got);
         rsp_type want;
         if (due_reports.size() == 0) begin
            $error("unexpected result item, status %0d", got.status);
            mismatches++;
            return;
         end
         want = due_reports.pop_front();
         if (got.status !== want.status) begin
            $error("status expected %0d got %0d", want.status, got.status);
            mismatches++;
         end
         if (got.packet_type !== want.packet_type) begin
            $error("packet_type expected %0h got %0h", want.packet_type, got.packet_type);
            mismatches++;
         end
         if (got.session_id !== want.session_id) begin
            $error("session_id expected %0h got %0h", want.session_id, got.session_id);
            mismatches++;
         end
         if (got.sequence_number !== want.sequence_number) begin
            $error("sequence_number expected %0h got %0h",
                   want.sequence_number, got.sequence_number);
            mismatches++;
         end
         if (got.payload_length !== want.payload_length) begin
            $error("payload_length expected %0h got %0h",
                   want.payload_length, got.payload_length);
            mismatches++;
         end
      endfunction
   endclass

   logic                     clock;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_ready;
   req_type                  req_data = '0;
   logic                     rsp_valid;
   logic                     rsp_ready = 1'b0;
   rsp_type                  rsp_data;
   logic                     csr_write_enable = 1'b0;
   logic [CSR_IDX_WIDTH-1:0] csr_index = '0;
   logic [CSR_WIDTH-1:0]     csr_write_data = '0;

   header_tracker tracker = new();
   logic [7:0]    pkt[$];
   bit            steady;
   int            stalled_cycles = 0;

   packet_header_checker i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_data         (rsp_data),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         stalled_cycles <= 0;
      end else begin
         stalled_cycles <= stalled_cycles + 1;
      end
      if (stalled_cycles >= WATCHDOG_LIMIT) begin
         $display("packet_header_checker verification failed");
         $finish;
      end
   end

   // result side: random back-pressure
   initial begin
      int stall;
      while (reset) @(posedge clock);
      forever begin
         stall = steady ? 0 : $urandom_range(0, 5);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         tracker.match_result(rsp_data);
      end
   end

   task automatic send_byte(input req_type item);
      int gap;
      gap = steady ? 0 : $urandom_range(0, 5);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (!req_ready);
      tracker.take_byte(item);
   endtask

   task automatic send_packet();
      req_type item;
      steady = ($urandom_range(0, 3) == 0);
      foreach (pkt[i]) begin
         item.data_byte = pkt[i];
         item.last_byte = (i == pkt.size() - 1);
         send_byte(item);
      end
   endtask

   task automatic build_packet(input logic [7:0] ver_byte, input logic [7:0] type_code,
                               input logic [15:0] length_code, input logic [31:0] session,
                               input logic [31:0] seq_no, input int payload_bytes);
      pkt.delete();
      pkt.push_back(MAGIC_0);
      pkt.push_back(MAGIC_1);
      pkt.push_back(MAGIC_2);
      pkt.push_back(MAGIC_3);
      pkt.push_back(ver_byte);
      pkt.push_back(type_code);
      for (int i = 0; i < 2; i++) pkt.push_back(length_code[8*i +: 8]);
      for (int i = 0; i < 4; i++) pkt.push_back(session[8*i +: 8]);
      for (int i = 0; i < 4; i++) pkt.push_back(seq_no[8*i +: 8]);
      for (int i = 0; i < payload_bytes; i++) pkt.push_back(8'($urandom_range(0, 255)));
   endtask

   task automatic trim_packet(input int keep);
      while (pkt.size() > keep) void'(pkt.pop_back());
   endtask

   // no register writes until the block has drained
   task automatic settle();
      req_valid <= 1'b0;
      while (tracker.due_reports.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic put_register(input logic [CSR_IDX_WIDTH-1:0] idx,
                               input logic [CSR_WIDTH-1:0] value);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= value;
      @(posedge clock);
      tracker.set_register(idx, value);
   endtask

   task automatic apply_settings(input logic [7:0] ver_byte, input logic [7:0] lowest,
                                 input logic [7:0] highest, input logic [12:0] limit);
      put_register(CSR_EXPECTED_VERSION, CSR_WIDTH'(ver_byte));
      put_register(CSR_TYPE_LOWEST, CSR_WIDTH'(lowest));
      put_register(CSR_TYPE_HIGHEST, CSR_WIDTH'(highest));
      put_register(CSR_MAX_PACKET_LENGTH, limit);
      csr_write_enable <= 1'b0;
   endtask

   task automatic random_packet();
      int         pick;
      int         room;
      int         plen;
      int         total;
      int         pos;
      logic [7:0] type_code;
      pick = $urandom_range(0, 99);
      room = int'(tracker.length_limit) - 16;
      if (room > 24) room = 24;
      if (room < 0) room = 0;
      if (tracker.type_low <= tracker.type_high)
         type_code = 8'($urandom_range(tracker.type_low, tracker.type_high));
      else
         type_code = 8'($urandom_range(0, 255));
      plen = $urandom_range(0, room);
      build_packet(tracker.version_reg, type_code, 16'(plen), $urandom, $urandom, plen);
      if (pick < 60) begin
         // well-formed
      end else if (pick < 68) begin
         trim_packet($urandom_range(1, 15));
      end else if (pick < 74) begin
         total = int'(tracker.length_limit) + $urandom_range(1, 8);
         build_packet(tracker.version_reg, type_code, 16'(total - 16), $urandom, $urandom,
                      total - 16);
      end else if (pick < 80) begin
         pos = $urandom_range(0, 3);
         pkt[pos] = pkt[pos] ^ 8'($urandom_range(1, 255));
      end else if (pick < 86) begin
         pkt[4] = pkt[4] ^ 8'($urandom_range(1, 255));
      end else if (pick < 92) begin
         build_packet(tracker.version_reg, type_code, 16'($urandom), $urandom, $urandom,
                      $urandom_range(0, 20));
      end else begin
         pkt[5] = 8'($urandom_range(0, 255));
      end
      send_packet();
   endtask

   initial begin
      int          sent;
      int          count;
      logic [7:0]  ver_byte;
      logic [7:0]  lowest;
      logic [7:0]  highest;
      logic [12:0] limit;

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // reset settings: version 1, types 0..255, max length 250
      build_packet(8'd1, 8'd0, 16'd0, 32'h0, 32'h0, 0);
      send_packet();
      build_packet(8'd1, 8'hFF, 16'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
      send_packet();
      build_packet(8'd1, 8'h5A, 16'd0, 32'h1, 32'h2, 0);
      trim_packet(1);
      send_packet();
      build_packet(8'd1, 8'h5A, 16'd0, 32'h1, 32'h2, 0);
      trim_packet(15);
      send_packet();
      build_packet(8'd1, 8'h10, 16'd3, 32'hA5A5_A5A5, 32'h5A5A_5A5A, 3);
      pkt[3] = 8'h00;
      send_packet();
      build_packet(8'd2, 8'h10, 16'd3, 32'hA5A5_A5A5, 32'h5A5A_5A5A, 3);
      send_packet();
      build_packet(8'd1, 8'h10, 16'd5, 32'h1, 32'h1, 4);
      send_packet();
      build_packet(8'd1, 8'h10, 16'hFFFF, 32'h1, 32'h1, 0);
      send_packet();
      // priority: short over magic, magic over version
      build_packet(8'd1, 8'h10, 16'd0, 32'h1, 32'h1, 0);
      pkt[0] = 8'h00;
      trim_packet(10);
      send_packet();
      build_packet(8'd9, 8'h10, 16'd0, 32'h1, 32'h1, 0);
      pkt[2] = 8'h00;
      send_packet();

      settle();
      apply_settings(8'd0, 8'd0, 8'd0, 13'd16);
      build_packet(8'd0, 8'd0, 16'd0, 32'hDEAD_BEEF, 32'hCAFE_F00D, 0);
      send_packet();
      build_packet(8'd0, 8'd1, 16'd0, 32'h1, 32'h1, 0);
      send_packet();
      build_packet(8'd0, 8'd0, 16'd1, 32'h1, 32'h1, 1);
      send_packet();
      // long over magic
      build_packet(8'd0, 8'd0, 16'd1, 32'h1, 32'h1, 1);
      pkt[1] = 8'h00;
      send_packet();

      settle();
      apply_settings(8'd255, 8'd255, 8'd255, 13'd24);
      build_packet(8'd255, 8'd255, 16'd8, 32'h0102_0304, 32'h0506_0708, 8);
      send_packet();
      build_packet(8'd255, 8'd255, 16'd9, 32'h1, 32'h1, 9);
      send_packet();
      build_packet(8'd255, 8'd254, 16'd2, 32'h1, 32'h1, 2);
      send_packet();

      // empty type range
      settle();
      apply_settings(8'd7, 8'd200, 8'd100, 13'd40);
      build_packet(8'd7, 8'd150, 16'd4, 32'h1, 32'h1, 4);
      send_packet();
      build_packet(8'd7, 8'd200, 16'd4, 32'h1, 32'h1, 4);
      send_packet();

      // maximum below the header size
      settle();
      apply_settings(8'd1, 8'd0, 8'd255, 13'd10);
      build_packet(8'd1, 8'd3, 16'd0, 32'h1, 32'h1, 0);
      trim_packet(12);
      send_packet();
      build_packet(8'd1, 8'd3, 16'd0, 32'h1, 32'h1, 0);
      send_packet();

      for (int phase = 0; phase < 6; phase++) begin
         settle();
         ver_byte = 8'($urandom_range(0, 255));
         lowest = 8'($urandom_range(0, 200));
         if ($urandom_range(0, 5) == 0) highest = 8'($urandom_range(0, 255));
         else highest = 8'($urandom_range(lowest, 255));
         limit = 13'($urandom_range(16, 64));
         apply_settings(ver_byte, lowest, highest, limit);
         sent = 0;
         count = 0;
         while (sent < 70 || count < 4) begin
            random_packet();
            sent += pkt.size();
            count++;
         end
      end

      settle();
      repeat (6) @(posedge clock);
      if (tracker.mismatches == 0 && tracker.due_reports.size() == 0) begin
         $display("packet_header_checker verification clean");
      end else begin
         $display("packet_header_checker verification failed");
      end
      $finish;
   end

endmodule

// ===== files.f =====
sv/phc_pkg.sv
sv/phc_front.sv
sv/phc_queue.sv
sv/phc_back.sv
sv/packet_header_checker.sv
dv/testbench.sv
